[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros, compiled out when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked check, disabled while reset is asserted
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALW(lbl, prop, msg)

`endif

`endif

[design/ebtc_pkg.sv]
// ----------------------------------------------------------------------------
// ebtc_pkg
// Shared types and codes of the eight-bit timer/counter
// ----------------------------------------------------------------------------
package ebtc_pkg;

  // bus command codes carried in tuser
  localparam logic [2:0] CMD_TICK        = 3'd0;
  localparam logic [2:0] CMD_WR_CTRL     = 3'd1;
  localparam logic [2:0] CMD_WR_COUNT    = 3'd2;
  localparam logic [2:0] CMD_WR_COMPARE  = 3'd3;
  localparam logic [2:0] CMD_RD_COUNT    = 3'd4;
  localparam logic [2:0] CMD_RD_FLAGS    = 3'd5;
  localparam logic [2:0] CMD_CLR_FLAGS   = 3'd6;

  // flag bit positions
  localparam int unsigned FLAG_OVF = 0;
  localparam int unsigned FLAG_CMP = 1;

  // stream widths
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CMD_W       = 3;

  // count clock source
  typedef enum logic [1:0] {
    SRC_STOP,
    SRC_PRESC,
    SRC_FALL,
    SRC_RISE
  } src_e;

  typedef struct packed {
    src_e       src;
    logic [3:0] shift;
  } clk_src_t;

  // one accepted input item
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
    logic       pin;
  } ebtc_item_t;

  // one result item
  typedef struct packed {
    logic [7:0] read_data;
    logic       ovf;
    logic       cmp;
  } ebtc_result_t;

  // clock select decode for both channel kinds
  function automatic clk_src_t clk_source(logic kind, logic [2:0] sel);
    clk_src_t r;
    r.src   = SRC_PRESC;
    r.shift = 4'd0;
    if (!kind) begin
      unique case (sel)
        3'd0: r.src = SRC_STOP;
        3'd1: r.shift = 4'd0;
        3'd2: r.shift = 4'd3;
        3'd3: r.shift = 4'd6;
        3'd4: r.shift = 4'd8;
        3'd5: r.shift = 4'd10;
        3'd6: r.src = SRC_FALL;
        default: r.src = SRC_RISE;
      endcase
    end else begin
      unique case (sel)
        3'd0: r.src = SRC_STOP;
        3'd1: r.shift = 4'd0;
        3'd2: r.shift = 4'd3;
        3'd3: r.shift = 4'd5;
        3'd4: r.shift = 4'd6;
        3'd5: r.shift = 4'd7;
        3'd6: r.shift = 4'd8;
        default: r.shift = 4'd10;
      endcase
    end
    return r;
  endfunction

endpackage

[design/eight_bit_timer_counter.sv]
// ----------------------------------------------------------------------------
// eight_bit_timer_counter
// Eight-bit timer/counter with prescaler behind a command stream
// ----------------------------------------------------------------------------
// pipeline: the input register, then the state update and result register;
//   a result is valid once its item has passed through both
// throughput: one item per cycle while m_axis_tready does not stall the result
// reset: rst_ni clears count, compare, control, prescaler, flags, pin history
//   and channel kind; both stream stages come out empty

`include "assert_macros.svh"

module eight_bit_timer_counter
  import ebtc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH    = 8,
  parameter int unsigned PRESCALE_WIDTH = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // channel kind register
  input  logic                   cfg_we_i,
  input  logic                   cfg_data_i,
  // command stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // write_data[7:0], ext_pin[8]
  input  logic [CMD_W-1:0]       s_axis_tuser,  // command[2:0]
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // read_data[7:0], overflow[8],
                                                 // compare[9]
);

  logic         in_valid_q, in_valid_d;
  ebtc_item_t   in_item_q;
  logic         out_valid_q, out_valid_d;
  ebtc_result_t out_res_q;
  ebtc_result_t core_res;
  logic         in_xfer;
  logic         advance;

  // stage control
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q.cmd  <= s_axis_tuser;
      in_item_q.data <= s_axis_tdata[7:0];
      in_item_q.pin  <= s_axis_tdata[8];
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  // timer state and register file
  ebtc_core #(
    .COUNT_WIDTH    (COUNT_WIDTH),
    .PRESCALE_WIDTH (PRESCALE_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .item_valid_i (advance),
    .item_i       (in_item_q),
    .result_o     (core_res)
  );

  // result stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.cmp, out_res_q.ovf, out_res_q.read_data};

  // an accepted item is held in the input stage next cycle
  `ASSERT_RST(a_in_loaded, in_xfer |=> in_valid_q,
    "accepted item missing from input stage")
  // a stalled input stage keeps its item
  `ASSERT_RST(a_in_hold, (in_valid_q && !advance) |=> (in_valid_q && $stable(in_item_q)),
    "stalled input item lost or changed")
  // a new result appears only after the core took an item
  `ASSERT_RST(a_out_from_core, $rose(m_axis_tvalid) |-> $past(advance),
    "result valid without a processed item")

endmodule

[design/ebtc_core.sv]
// ----------------------------------------------------------------------------
// ebtc_core
// Timer state, prescaler and register file; one item applied per strobe
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ebtc_core
  import ebtc_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH    = 8,
  parameter int unsigned PRESCALE_WIDTH = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_data_i,
  input  logic         item_valid_i,
  input  ebtc_item_t   item_i,
  output ebtc_result_t result_o
);

  logic [COUNT_WIDTH-1:0]    count_q, count_d;
  logic [COUNT_WIDTH-1:0]    compare_q, compare_d;
  logic [2:0]                csel_q, csel_d;
  logic                      com_q, com_d;
  logic [PRESCALE_WIDTH-1:0] presc_q, presc_d;
  logic [1:0]                flags_q, flags_d;
  logic                      pin_q, pin_d;
  logic                      kind_q;

  clk_src_t                  src;
  logic [PRESCALE_WIDTH-1:0] presc_inc;
  logic [PRESCALE_WIDTH-1:0] low_mask;
  logic                      count_event;
  logic                      match;
  logic                      at_max;
  logic [7:0]                rdata;

  // clock source and count event of a tick
  assign src       = clk_source(kind_q, csel_q);
  assign presc_inc = presc_q + PRESCALE_WIDTH'(1);
  assign low_mask  = ~({PRESCALE_WIDTH{1'b1}} << src.shift);
  assign match     = com_q && (count_q == compare_q);
  assign at_max    = (count_q == {COUNT_WIDTH{1'b1}});

  always_comb begin
    case (src.src)
      SRC_STOP:  count_event = 1'b0;
      SRC_RISE:  count_event = !pin_q && item_i.pin;
      SRC_FALL:  count_event = pin_q && !item_i.pin;
      default:   count_event = ((presc_inc & low_mask) == '0);
    endcase
  end

  // apply one item to the state
  always_comb begin
    count_d   = count_q;
    compare_d = compare_q;
    csel_d    = csel_q;
    com_d     = com_q;
    presc_d   = presc_q;
    flags_d   = flags_q;
    pin_d     = pin_q;
    rdata     = 8'd0;
    unique case (item_i.cmd)
      CMD_TICK: begin
        presc_d = presc_inc;
        pin_d   = item_i.pin;
        if (count_event) begin
          if (match) begin
            count_d           = '0;
            flags_d[FLAG_CMP] = 1'b1;
          end else if (at_max) begin
            count_d           = '0;
            flags_d[FLAG_OVF] = 1'b1;
          end else begin
            count_d = count_q + COUNT_WIDTH'(1);
          end
        end
      end
      CMD_WR_CTRL: begin
        csel_d = item_i.data[2:0];
        com_d  = item_i.data[3];
      end
      CMD_WR_COUNT:   count_d   = COUNT_WIDTH'(item_i.data);
      CMD_WR_COMPARE: compare_d = COUNT_WIDTH'(item_i.data);
      CMD_RD_COUNT:   rdata     = count_q[7:0];
      CMD_RD_FLAGS:   rdata     = {6'd0, flags_q};
      CMD_CLR_FLAGS:  flags_d   = flags_q & ~item_i.data[1:0];
      default: ;
    endcase
  end

  assign result_o.read_data = rdata;
  assign result_o.ovf       = flags_d[FLAG_OVF];
  assign result_o.cmp       = flags_d[FLAG_CMP];

  // state registers, updated only for a presented item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      compare_q <= '0;
      csel_q    <= 3'd0;
      com_q     <= 1'b0;
      presc_q   <= '0;
      flags_q   <= 2'd0;
      pin_q     <= 1'b0;
    end else if (item_valid_i) begin
      count_q   <= count_d;
      compare_q <= compare_d;
      csel_q    <= csel_d;
      com_q     <= com_d;
      presc_q   <= presc_d;
      flags_q   <= flags_d;
      pin_q     <= pin_d;
    end
  end

  // channel kind register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
    end else if (cfg_we_i) begin
      kind_q <= cfg_data_i;
    end
  end

  // flags are only raised by a tick
  `ASSERT_RST(a_flag_rise_on_tick,
    ($rose(flags_q[FLAG_OVF]) || $rose(flags_q[FLAG_CMP])) |->
      $past(item_valid_i && (item_i.cmd == CMD_TICK)),
    "flag raised by a non-tick item")
  // compare flag needs clear-on-compare mode
  `ASSERT_RST(a_cmp_needs_com, $rose(flags_q[FLAG_CMP]) |-> $past(com_q),
    "compare flag set outside clear-on-compare mode")
  // prescaler moves only on ticks
  `ASSERT_RST(a_presc_on_tick,
    !$stable(presc_q) |-> $past(item_valid_i && (item_i.cmd == CMD_TICK)),
    "prescaler advanced without a tick")

endmodule

[tb/eight_bit_timer_counter_tb.sv]
// ----------------------------------------------------------------------------
// eight_bit_timer_counter_tb
// Self-checking regression of the timer/counter command stream: a directed
// pass over wrap, compare clear, flag writes and external edges, then random
// control/compare/count setups followed by tick bursts, for both channel
// kinds. Every result transfer is checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module eight_bit_timer_counter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ebtc_pkg::*;

  // command seven is not decoded by the block
  localparam logic [2:0] CMD_UNUSED  = 3'd7;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES = 4;

  // scoreboard: timer predictor plus queue of expected results
  class timer_scoreboard;
    logic [7:0]  count_q;
    logic [7:0]  compare_q;
    logic [2:0]  clk_sel;
    logic        clear_on_match;
    logic [9:0]  presc_q;
    logic        ovf_q;
    logic        cmp_q;
    logic        pin_q;
    logic        chan_kind;
    ebtc_result_t expected_results[$];
    int unsigned items_noted;
    int unsigned results_checked;
    int unsigned wraps_predicted;
    int unsigned matches_predicted;
    int unsigned failures;

    function new();
      count_q = '0;
      compare_q = '0;
      clk_sel = '0;
      clear_on_match = 1'b0;
      presc_q = '0;
      ovf_q = 1'b0;
      cmp_q = 1'b0;
      pin_q = 1'b0;
      chan_kind = 1'b0;
      items_noted = 0;
      results_checked = 0;
      wraps_predicted = 0;
      matches_predicted = 0;
      failures = 0;
    endfunction

    function void set_channel_kind(logic kind);
      chan_kind = kind;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // one count event: compare clear wins over wrap
    function void bump_count();
      if (clear_on_match && count_q == compare_q) begin
        count_q = '0;
        cmp_q = 1'b1;
        matches_predicted++;
      end else if (count_q == 8'hFF) begin
        count_q = '0;
        ovf_q = 1'b1;
        wraps_predicted++;
      end else begin
        count_q = count_q + 8'd1;
      end
    endfunction

    // one tick: prescaler always advances, then the selected source decides
    function void tick(logic pin);
      src_e        src;
      int unsigned shift;
      logic        fire;
      src = SRC_PRESC;
      shift = 0;
      // divider table index by clock select, kind 0 has the pin edges
      case (clk_sel)
        3'd0: src = SRC_STOP;
        3'd1: shift = 0;
        3'd2: shift = 3;
        3'd3: shift = chan_kind ? 5 : 6;
        3'd4: shift = chan_kind ? 6 : 8;
        3'd5: shift = chan_kind ? 7 : 10;
        3'd6: if (chan_kind) shift = 8; else src = SRC_FALL;
        default: if (chan_kind) shift = 10; else src = SRC_RISE;
      endcase
      presc_q = presc_q + 10'd1;
      case (src)
        SRC_STOP: fire = 1'b0;
        SRC_RISE: fire = !pin_q && pin;
        SRC_FALL: fire = pin_q && !pin;
        default:  fire = ((presc_q & ((10'd1 << shift) - 10'd1)) == 10'd0);
      endcase
      pin_q = pin;
      if (fire) bump_count();
    endfunction

    // accepted input transfer: update state, queue the result
    function void note_transfer(logic [2:0] cmd, logic [7:0] data, logic pin);
      ebtc_result_t res;
      res.read_data = 8'h00;
      case (cmd)
        CMD_TICK:       tick(pin);
        CMD_WR_CTRL: begin
          clk_sel = data[2:0];
          clear_on_match = data[3];
        end
        CMD_WR_COUNT:   count_q = data;
        CMD_WR_COMPARE: compare_q = data;
        CMD_RD_COUNT:   res.read_data = count_q;
        CMD_RD_FLAGS:   res.read_data = {6'd0, cmp_q, ovf_q};
        CMD_CLR_FLAGS: begin
          if (data[FLAG_OVF]) ovf_q = 1'b0;
          if (data[FLAG_CMP]) cmp_q = 1'b0;
        end
        default: ;
      endcase
      res.ovf = ovf_q;
      res.cmp = cmp_q;
      expected_results.push_back(res);
      items_noted++;
    endfunction

    // accepted result transfer: compare against the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] tdata);
      ebtc_result_t exp_res;
      if (expected_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] result with nothing expected: tdata=%h", $realtime, tdata);
        return;
      end
      exp_res = expected_results.pop_front();
      results_checked++;
      if (tdata[7:0] !== exp_res.read_data || tdata[8] !== exp_res.ovf ||
          tdata[9] !== exp_res.cmp) begin
        failures++;
        if (failures <= 10)
          $display(
            "[%0t] result %0d mismatch: read exp %h got %h, ovf exp %b got %b, cmp exp %b got %b",
            $realtime, results_checked, exp_res.read_data, tdata[7:0],
            exp_res.ovf, tdata[8], exp_res.cmp, tdata[9]);
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic                   cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // write_data[7:0], ext_pin[8]
  logic [CMD_W-1:0]       s_axis_tuser;   // command[2:0]
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // read_data[7:0], overflow[8], compare[9]

  timer_scoreboard sb;
  logic            steady_in;
  logic            steady_out;
  logic            hold_pending;
  logic            kind_now;

  eight_bit_timer_counter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // result receiver: per-transfer stalls, one long hold-off on request
  initial begin : receiver
    int unsigned stall;
    m_axis_tready = 1'b0;
    steady_out = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_pending) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_pending = 1'b0;
      end
      stall = steady_out ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      if ($urandom_range(0, 39) == 0) steady_out = ~steady_out;
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("eight_bit_timer_counter regression: fail");
    $finish;
  end

  // offer one command until it transfers
  task automatic send_item(logic [2:0] cmd, logic [7:0] data, logic pin);
    int unsigned gap;
    gap = steady_in ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, pin, data};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_transfer(cmd, data, pin);
  endtask

  // drain all results, then write the channel kind
  task automatic write_channel_kind(logic kind);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= kind;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_channel_kind(kind);
    kind_now = kind;
  endtask

  // random setups with tick bursts, plus some noise
  task automatic run_random(int unsigned n_items);
    int unsigned stop_at;
    int unsigned burst;
    logic [2:0]  sel;
    logic [7:0]  cmp_val;
    logic [7:0]  cnt_val;
    stop_at = sb.items_noted + n_items;
    while (sb.items_noted < stop_at) begin
      steady_in = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 7) begin
        // fast sources most of the time so wraps and matches happen
        if ($urandom_range(0, 9) < 7)
          sel = kind_now ? 3'($urandom_range(1, 3))
                         : ($urandom_range(0, 1) ? 3'($urandom_range(1, 2))
                                                 : 3'($urandom_range(6, 7)));
        else
          sel = 3'($urandom_range(0, 7));
        send_item(CMD_WR_CTRL, {4'($urandom), 1'($urandom), sel}, 1'($urandom));
        cmp_val = $urandom_range(0, 1) ? 8'($urandom_range(0, 30)) : 8'($urandom);
        if ($urandom_range(0, 1)) send_item(CMD_WR_COMPARE, cmp_val, 1'($urandom));
        if ($urandom_range(0, 2) != 0) begin
          case ($urandom_range(0, 2))
            0: cnt_val = cmp_val - 8'($urandom_range(0, 5));
            1: cnt_val = 8'd250 + 8'($urandom_range(0, 5));
            default: cnt_val = 8'($urandom);
          endcase
          send_item(CMD_WR_COUNT, cnt_val, 1'($urandom));
        end
        burst = $urandom_range(8, 60);
        repeat (burst) begin
          case ($urandom_range(0, 9))
            0: send_item(CMD_RD_COUNT, 8'($urandom), 1'($urandom));
            1: send_item(CMD_RD_FLAGS, 8'($urandom), 1'($urandom));
            2: send_item(CMD_CLR_FLAGS, 8'($urandom), 1'($urandom));
            default: send_item(CMD_TICK, 8'($urandom), 1'($urandom));
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 8))
          send_item(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom));
      end
    end
  endtask

  // main sequence
  initial begin : stimulus
    int unsigned waited;
    sb = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_TICK;
    steady_in     = 1'b0;
    hold_pending  = 1'b0;
    kind_now      = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_channel_kind(1'b0);

    // directed: wrap at max, compare clear, flag writes, pin edges
    send_item(CMD_RD_COUNT,   8'h00, 1'b0);
    send_item(CMD_WR_CTRL,    8'h01, 1'b0);
    send_item(CMD_WR_COUNT,   8'hFE, 1'b0);
    send_item(CMD_TICK,       8'h00, 1'b1);
    send_item(CMD_TICK,       8'h00, 1'b0);
    send_item(CMD_RD_FLAGS,   8'h00, 1'b0);
    send_item(CMD_CLR_FLAGS,  8'hFC, 1'b0);   // upper bits do nothing
    send_item(CMD_CLR_FLAGS,  8'h01, 1'b0);
    send_item(CMD_WR_COMPARE, 8'h05, 1'b0);
    send_item(CMD_WR_CTRL,    8'hF9, 1'b0);   // bit 3 sets clear-on-compare, bits 7:4 ignored
    send_item(CMD_WR_COUNT,   8'h04, 1'b0);
    send_item(CMD_TICK,       8'h00, 1'b0);
    send_item(CMD_TICK,       8'h00, 1'b1);   // match clears the count
    send_item(CMD_WR_COUNT,   8'hFF, 1'b0);   // count above compare
    send_item(CMD_TICK,       8'h00, 1'b0);   // wraps and sets overflow
    send_item(CMD_UNUSED,     8'hFF, 1'b1);
    send_item(CMD_RD_FLAGS,   8'h00, 1'b0);
    send_item(CMD_CLR_FLAGS,  8'hFF, 1'b0);
    send_item(CMD_WR_CTRL,    8'h07, 1'b0);   // rising pin edges
    send_item(CMD_TICK,       8'h00, 1'b1);
    send_item(CMD_TICK,       8'h00, 1'b1);
    send_item(CMD_WR_CTRL,    8'h06, 1'b0);   // falling pin edges
    send_item(CMD_TICK,       8'h00, 1'b0);
    send_item(CMD_RD_COUNT,   8'h00, 1'b0);
    send_item(CMD_WR_COMPARE, 8'hFF, 1'b0);
    send_item(CMD_WR_CTRL,    8'h00, 1'b0);   // stopped

    run_random(700);

    // second kind, with one long receiver hold-off
    write_channel_kind(1'b1);
    hold_pending = 1'b1;
    run_random(700);

    write_channel_kind(1'b0);
    run_random(600);

    // drain
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (sb.pending() != 0) begin
      $display("timeout with %0d results outstanding", sb.pending());
      $display("eight_bit_timer_counter regression: fail");
    end else begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
      $display("covered %0d commands over both channel kinds, %0d results checked",
               sb.items_noted, sb.results_checked);
      $display("predicted %0d counter wraps and %0d compare clears, %0d failures",
               sb.wraps_predicted, sb.matches_predicted, sb.failures);
      if (sb.failures == 0)
        $display("eight_bit_timer_counter regression: pass");
      else
        $display("eight_bit_timer_counter regression: fail");
    end
    $finish;
  end

endmodule

[eight_bit_timer_counter.f]
+incdir+design
design/ebtc_pkg.sv
design/ebtc_core.sv
design/eight_bit_timer_counter.sv
tb/eight_bit_timer_counter_tb.sv
